### sv/slrb_pkg.sv
// Shared constants for the serial line receive buffer.
// Field widths, operation codes and line-end characters; no dependencies.
package slrb_pkg;

  localparam int OP_W   = 2;
  localparam int BYTE_W = 8;
  localparam int IDX_W  = 6;
  localparam int CNT_W  = 8;

  localparam logic [OP_W-1:0] OP_RECEIVE = 2'd0;
  localparam logic [OP_W-1:0] OP_POP     = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

  localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;

endpackage

### sv/slrb_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Standalone; no package dependencies.
module slrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 40
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/serial_line_receive_buffer.sv
// Serial line receive buffer: byte store that assembles characters into lines.
// A receive steps through RX_RD, RX_WR, PEEK and DONE; a NUL byte or the unused code 3 goes straight to PEEK.
// One item at a time; busy_o stays high until the result strobe has gone out.
// After reset a zeroing sweep over all DEPTH entries runs with busy_o high.
// The result is shown for one cycle on valid_o; the receiver cannot stall.
// Depends on slrb_pkg and slrb_ram.
module serial_line_receive_buffer #(
  parameter int DEPTH = 40
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [slrb_pkg::OP_W-1:0]  operation_i,
  input  logic [slrb_pkg::BYTE_W-1:0] rx_byte_i,
  input  logic [slrb_pkg::IDX_W-1:0] peek_index_i,
  output logic                       valid_o,
  output logic [slrb_pkg::BYTE_W-1:0] peek_byte_o,
  output logic [slrb_pkg::CNT_W-1:0] line_count_o,
  output logic [slrb_pkg::IDX_W-1:0] fill_index_o,
  output logic                       overflow_o
);

  import slrb_pkg::*;

  // Address width of the store; counters also hold DEPTH+1 (line length
  // when no terminator is found).
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 2);

  localparam logic [CW-1:0] LAST   = CW'(DEPTH - 1);
  localparam logic [CW-1:0] NO_END = CW'(DEPTH + 1);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLEAR = 3'd1;
  localparam logic [2:0] ST_RX_RD = 3'd2;
  localparam logic [2:0] ST_RX_WR = 3'd3;
  localparam logic [2:0] ST_SCAN  = 3'd4;
  localparam logic [2:0] ST_SHIFT = 3'd5;
  localparam logic [2:0] ST_PEEK  = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0]        state_q, state_d;
  logic [BYTE_W-1:0] byte_q, byte_d;
  logic [IDX_W-1:0]  peek_q, peek_d;
  logic [CW-1:0]     wp_q, wp_d;
  logic [CNT_W-1:0]  lines_q, lines_d;
  logic              ovf_q, ovf_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [CW-1:0]     chk_q, chk_d;
  logic              rv_q, rv_d;
  logic [CW-1:0]     len_q, len_d;
  logic              wr_pend_q, wr_pend_d;
  logic [CW-1:0]     wr_addr_q, wr_addr_d;
  logic              wr_src_q, wr_src_d;
  logic              rpt_q, rpt_d;
  logic              pk_ok_q, pk_ok_d;

  // Store port signals.
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  // Helpers.
  logic [CW-1:0]      wp_m1;
  logic [CW:0]        src;
  logic [CW-1:0]      scan_len;
  logic               is_eol;
  logic [BYTE_W-1:0]  rx_val;
  logic               prev_nz;
  logic               advance;
  logic [AW+IDX_W-1:0] peek_ext;
  logic [AW+IDX_W-1:0] wp_ext;

  assign wp_m1    = wp_q - 1'b1;
  assign src      = {1'b0, cnt_q} + {1'b0, len_q};
  assign scan_len = (ram_rdata == '0) ? (chk_q + 1'b1) : NO_END;
  assign is_eol   = (byte_q == CH_CR) || (byte_q == CH_LF);
  assign rx_val   = is_eol ? '0 : byte_q;
  assign prev_nz  = (wp_q != '0) && (ram_rdata != '0);
  // Advance unless this would leave two zeros in a row; a line end at slot zero holds.
  assign advance  = !is_eol || prev_nz;
  assign peek_ext = {{AW{1'b0}}, peek_q};

  slrb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    byte_d    = byte_q;
    peek_d    = peek_q;
    wp_d      = wp_q;
    lines_d   = lines_q;
    ovf_d     = ovf_q;
    cnt_d     = cnt_q;
    chk_d     = chk_q;
    rv_d      = rv_q;
    len_d     = len_q;
    wr_pend_d = wr_pend_q;
    wr_addr_d = wr_addr_q;
    wr_src_d  = wr_src_q;
    rpt_d     = rpt_q;
    pk_ok_d   = pk_ok_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          byte_d = rx_byte_i;
          peek_d = peek_index_i;
          case (operation_i)
            OP_RECEIVE: begin
              // A zero byte changes nothing; go straight to the report.
              state_d = (rx_byte_i == '0) ? ST_PEEK : ST_RX_RD;
            end
            OP_POP: begin
              cnt_d   = '0;
              rv_d    = 1'b0;
              state_d = ST_SCAN;
            end
            OP_CLEAR: begin
              cnt_d   = '0;
              rpt_d   = 1'b1;
              state_d = ST_CLEAR;
            end
            default: begin
              state_d = ST_PEEK;
            end
          endcase
        end
      end

      ST_CLEAR: begin
        // Zero one entry per cycle.
        ram_we    = 1'b1;
        ram_waddr = cnt_q[AW-1:0];
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          wp_d    = '0;
          lines_d = '0;
          ovf_d   = 1'b0;
          rpt_d   = 1'b0;
          state_d = rpt_q ? ST_PEEK : ST_IDLE;
        end
      end

      ST_RX_RD: begin
        // Fetch the previous entry to check for a double zero.
        ram_re    = 1'b1;
        ram_raddr = wp_m1[AW-1:0];
        state_d   = ST_RX_WR;
      end

      ST_RX_WR: begin
        ram_we    = 1'b1;
        ram_waddr = wp_q[AW-1:0];
        ram_wdata = rx_val;
        if (is_eol) begin
          lines_d = lines_q + 1'b1;
        end
        if (advance) begin
          if (wp_q < LAST) begin
            wp_d = wp_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
        end
        state_d = ST_PEEK;
      end

      ST_SCAN: begin
        // Stream reads from the front; stop at the first zero or the end.
        if (rv_q && ((ram_rdata == '0) || (chk_q == LAST))) begin
          len_d     = scan_len;
          wp_d      = (wp_q > scan_len) ? (wp_q - scan_len) : '0;
          lines_d   = lines_q - 1'b1;
          cnt_d     = '0;
          wr_pend_d = 1'b0;
          state_d   = ST_SHIFT;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = cnt_q[AW-1:0];
          chk_d     = cnt_q;
          rv_d      = 1'b1;
          cnt_d     = cnt_q + 1'b1;
        end
      end

      ST_SHIFT: begin
        // Read entry k+len through the registered read port, then write it to k; past the end, zero-fill.
        if (wr_pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = wr_addr_q[AW-1:0];
          ram_wdata = wr_src_q ? ram_rdata : '0;
        end
        if (cnt_q <= LAST) begin
          if (src < (CW + 1)'(DEPTH)) begin
            ram_re    = 1'b1;
            ram_raddr = src[AW-1:0];
            wr_src_d  = 1'b1;
          end else begin
            wr_src_d  = 1'b0;
          end
          wr_pend_d = 1'b1;
          wr_addr_d = cnt_q;
          cnt_d     = cnt_q + 1'b1;
        end else begin
          wr_pend_d = 1'b0;
          state_d   = ST_PEEK;
        end
      end

      ST_PEEK: begin
        pk_ok_d   = ({3'b000, peek_q} < 9'(DEPTH));
        ram_re    = 1'b1;
        ram_raddr = peek_ext[AW-1:0];
        state_d   = ST_DONE;
      end

      ST_DONE: begin
        state_d = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      wp_q      <= '0;
      lines_q   <= '0;
      ovf_q     <= 1'b0;
      cnt_q     <= '0;
      rv_q      <= 1'b0;
      wr_pend_q <= 1'b0;
      rpt_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      wp_q      <= wp_d;
      lines_q   <= lines_d;
      ovf_q     <= ovf_d;
      cnt_q     <= cnt_d;
      rv_q      <= rv_d;
      wr_pend_q <= wr_pend_d;
      rpt_q     <= rpt_d;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    byte_q    <= byte_d;
    peek_q    <= peek_d;
    chk_q     <= chk_d;
    len_q     <= len_d;
    wr_addr_q <= wr_addr_d;
    wr_src_q  <= wr_src_d;
    pk_ok_q   <= pk_ok_d;
  end

  assign wp_ext       = {{IDX_W{1'b0}}, wp_q[AW-1:0]};
  assign busy_o       = (state_q != ST_IDLE);
  assign valid_o      = (state_q == ST_DONE);
  assign peek_byte_o  = pk_ok_q ? ram_rdata : '0;
  assign line_count_o = lines_q;
  assign fill_index_o = wp_ext[IDX_W-1:0];
  assign overflow_o   = ovf_q;

  // Every result strobe returns the block to idle.
  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !busy_o)
    else $error("block did not return to idle after the result");

  // An accepted transfer always starts work.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted transfer did not raise busy");

  // Write position never leaves the store.
  a_wp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wp_q <= LAST)
    else $error("write position beyond the store");

  // Status holds while idle and nothing is accepted.
  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy_o && !start_i) |=> ($stable(lines_q) && $stable(wp_q) && $stable(ovf_q)))
    else $error("status changed while idle");

endmodule

### tb/tb_top.sv
// Self-checking bench for serial_line_receive_buffer: directed table, then random line traffic.
// Holds its own model of the line store and compares every result strobe field by field.
// Depends on slrb_pkg and the serial_line_receive_buffer RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import slrb_pkg::*;

  localparam int DEPTH = 40;
  localparam int RANDOM_ITEMS = 1230;
  // Code 3 is not decoded by the block: no state change, status still reported.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] peek_byte;
    logic [CNT_W-1:0]  line_count;
    logic [IDX_W-1:0]  fill_index;
    logic              overflow;
  } line_status_t;

  // One row of the directed table; reps repeats the same transfer.
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] rx;
    logic [IDX_W-1:0]  peek;
    logic [7:0]        reps;
    logic              typed;
    line_status_t      want;
  } directed_row_t;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] rx;
    logic [IDX_W-1:0]  peek;
    bit                typed;
    line_status_t      want;
    bit                drain;
  } line_cmd_t;

  localparam line_status_t ST_EMPTY = '{8'h00, 8'h00, 6'd0, 1'b0};

  // Rows marked typed carry a status that follows directly from reset or a clear;
  // the rest are checked against the line store model.
  localparam directed_row_t LINE_SCRIPT [25] = '{
    // unused code with every input bit high, peek past the end of the store
    '{OP_UNUSED,  8'hFF, 6'd63, 8'd1,  1'b1, ST_EMPTY},
    // NUL byte is dropped
    '{OP_RECEIVE, 8'h00, 6'd0,  8'd1,  1'b1, ST_EMPTY},
    '{OP_RECEIVE, 8'h41, 6'd0,  8'd1,  1'b1, '{8'h41, 8'h00, 6'd1, 1'b0}},
    '{OP_RECEIVE, 8'hFF, 6'd1,  8'd1,  1'b1, '{8'hFF, 8'h00, 6'd2, 1'b0}},
    // CR ends a line and advances past the stored zero
    '{OP_RECEIVE, CH_CR, 6'd2,  8'd1,  1'b1, '{8'h00, 8'h01, 6'd3, 1'b0}},
    // LF right after CR: counted, but the position holds (no double zero)
    '{OP_RECEIVE, CH_LF, 6'd3,  8'd1,  1'b1, '{8'h00, 8'h02, 6'd3, 1'b0}},
    '{OP_RECEIVE, 8'h42, 6'd3,  8'd1,  1'b0, ST_EMPTY},
    '{OP_RECEIVE, 8'h01, 6'd4,  8'd1,  1'b0, ST_EMPTY},
    '{OP_RECEIVE, CH_LF, 6'd5,  8'd1,  1'b0, ST_EMPTY},
    '{OP_POP,     8'h00, 6'd0,  8'd1,  1'b0, ST_EMPTY},
    '{OP_POP,     8'h00, 6'd2,  8'd1,  1'b0, ST_EMPTY},
    '{OP_POP,     8'h00, 6'd0,  8'd1,  1'b0, ST_EMPTY},
    // pop with no lines held: the count wraps below zero
    '{OP_POP,     8'h00, 6'd0,  8'd1,  1'b0, ST_EMPTY},
    '{OP_CLEAR,   8'hFF, 6'd0,  8'd1,  1'b1, ST_EMPTY},
    // line end at slot zero holds the position
    '{OP_RECEIVE, CH_CR, 6'd0,  8'd1,  1'b1, '{8'h00, 8'h01, 6'd0, 1'b0}},
    // fill up to the last slot, then overwrite it and raise overflow
    '{OP_RECEIVE, 8'h78, 6'd39, 8'd38, 1'b0, ST_EMPTY},
    '{OP_RECEIVE, 8'h79, 6'd38, 8'd1,  1'b0, ST_EMPTY},
    '{OP_RECEIVE, 8'h7A, 6'd39, 8'd1,  1'b0, ST_EMPTY},
    '{OP_RECEIVE, 8'h77, 6'd39, 8'd1,  1'b0, ST_EMPTY},
    '{OP_RECEIVE, CH_CR, 6'd39, 8'd1,  1'b0, ST_EMPTY},
    // pop keeps the overflow flag
    '{OP_POP,     8'h00, 6'd39, 8'd1,  1'b0, ST_EMPTY},
    '{OP_CLEAR,   8'h00, 6'd39, 8'd1,  1'b1, ST_EMPTY},
    // full store with no zero anywhere, then pop the whole thing away
    '{OP_RECEIVE, 8'h7F, 6'd20, 8'd40, 1'b0, ST_EMPTY},
    '{OP_POP,     8'h00, 6'd39, 8'd1,  1'b0, ST_EMPTY},
    '{OP_CLEAR,   8'h00, 6'd63, 8'd1,  1'b1, ST_EMPTY}
  };

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic [OP_W-1:0]   operation_i = OP_UNUSED;
  logic [BYTE_W-1:0] rx_byte_i = '0;
  logic [IDX_W-1:0]  peek_index_i = '0;
  logic              busy_o;
  logic              valid_o;
  logic [BYTE_W-1:0] peek_byte_o;
  logic [CNT_W-1:0]  line_count_o;
  logic [IDX_W-1:0]  fill_index_o;
  logic              overflow_o;

  // Model of the line store, advanced once per accepted transfer.
  logic [BYTE_W-1:0] line_mem [DEPTH];
  int                fill_pos;
  logic [CNT_W-1:0]  lines_cnt;
  logic              ovf_seen;

  line_cmd_t    line_cmd_q [$];
  line_status_t pending_status_q [$];
  int           counted_cmds;
  int           mismatches;

  serial_line_receive_buffer #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .operation_i (operation_i),
    .rx_byte_i   (rx_byte_i),
    .peek_index_i(peek_index_i),
    .valid_o     (valid_o),
    .peek_byte_o (peek_byte_o),
    .line_count_o(line_count_o),
    .fill_index_o(fill_index_o),
    .overflow_o  (overflow_o)
  );

  always #1 clk_i = ~clk_i;

  // Hard stop in case the block hangs or never strobes a result.
  initial begin : watchdog
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic void wipe_lines();
    int j;
    for (j = 0; j < DEPTH; j++) line_mem[j] = '0;
    fill_pos  = 0;
    lines_cnt = '0;
    ovf_seen  = 1'b0;
  endfunction

  // Apply one command to the model and return the status the block must report.
  function automatic line_status_t next_line_status(input line_cmd_t cmd);
    line_status_t st;
    int           span;
    int           j;
    bit           step;
    case (cmd.op)
      OP_RECEIVE: begin
        if (cmd.rx != 8'h00) begin
          line_mem[fill_pos] = cmd.rx;
          if (cmd.rx == CH_CR || cmd.rx == CH_LF) begin
            line_mem[fill_pos] = 8'h00;
            lines_cnt = lines_cnt + 8'd1;
          end
          // advance unless this would leave two zeros in a row; a line end at slot zero holds
          step = (line_mem[fill_pos] != 8'h00) ||
                 (fill_pos > 0 && line_mem[fill_pos - 1] != 8'h00);
          if (step) begin
            if (fill_pos < DEPTH - 1) fill_pos++;
            else ovf_seen = 1'b1;
          end
        end
      end
      OP_POP: begin
        // line length including its terminator; DEPTH+1 when there is none
        span = 0;
        while (span < DEPTH && line_mem[span] != 8'h00) span++;
        span++;
        fill_pos = (fill_pos > span) ? fill_pos - span : 0;
        for (j = span; j < DEPTH; j++) line_mem[j - span] = line_mem[j];
        for (j = (span <= DEPTH) ? DEPTH - span : 0; j < DEPTH; j++) line_mem[j] = 8'h00;
        lines_cnt = lines_cnt - 8'd1;
      end
      OP_CLEAR: wipe_lines();
      default: ;
    endcase
    st.peek_byte  = (cmd.peek < DEPTH) ? line_mem[cmd.peek] : 8'h00;
    st.line_count = lines_cnt;
    st.fill_index = fill_pos[IDX_W-1:0];
    st.overflow   = ovf_seen;
    return st;
  endfunction

  // Queue one random-part command; peek mostly inside the store, sometimes past it.
  function automatic void add_item(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] rx);
    line_cmd_t cmd;
    cmd.op    = op;
    cmd.rx    = rx;
    cmd.peek  = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(40, 63))
                                            : 6'($urandom_range(0, 39));
    cmd.typed = 1'b0;
    cmd.want  = ST_EMPTY;
    cmd.drain = ($urandom_range(0, 49) == 0);
    line_cmd_q.push_back(cmd);
    // NUL bytes and the unused code leave the block untouched; don't count them
    if (op != OP_UNUSED && !(op == OP_RECEIVE && rx == 8'h00)) counted_cmds++;
  endfunction

  // Check every result strobe against the oldest pending status.
  always @(posedge clk_i) begin : check_results
    line_status_t want;
    if (rst_ni && valid_o) begin
      if (pending_status_q.size() == 0) begin
        $error("result strobe with no transfer pending: peek_byte %0h line_count %0d",
               peek_byte_o, line_count_o);
        mismatches++;
      end else begin
        want = pending_status_q.pop_front();
        if (peek_byte_o !== want.peek_byte) begin
          $error("peek_byte: expected %0h, got %0h", want.peek_byte, peek_byte_o);
          mismatches++;
        end
        if (line_count_o !== want.line_count) begin
          $error("line_count: expected %0d, got %0d", want.line_count, line_count_o);
          mismatches++;
        end
        if (fill_index_o !== want.fill_index) begin
          $error("fill_index: expected %0d, got %0d", want.fill_index, fill_index_o);
          mismatches++;
        end
        if (overflow_o !== want.overflow) begin
          $error("overflow: expected %0b, got %0b", want.overflow, overflow_o);
          mismatches++;
        end
      end
    end
  end

  initial begin : drive_transfers
    line_cmd_t    cmd;
    line_status_t st;
    int           k;
    int           r;
    int           kind;
    int           len;
    int           first_random;
    int           burst_left;
    bit           hold_high;

    mismatches   = 0;
    counted_cmds = 0;
    wipe_lines();

    // Expand the directed table.
    for (k = 0; k < $size(LINE_SCRIPT); k++) begin
      for (r = 0; r < LINE_SCRIPT[k].reps; r++) begin
        cmd.op    = LINE_SCRIPT[k].op;
        cmd.rx    = LINE_SCRIPT[k].rx;
        cmd.peek  = LINE_SCRIPT[k].peek;
        cmd.typed = LINE_SCRIPT[k].typed;
        cmd.want  = LINE_SCRIPT[k].want;
        cmd.drain = 1'b0;
        line_cmd_q.push_back(cmd);
      end
    end
    first_random = line_cmd_q.size();

    // Random traffic: mostly whole lines and pops, some clears, stray bytes and junk.
    while (counted_cmds < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        // now and then a long line that runs into the end of the store
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 45) : $urandom_range(0, 12);
        repeat (len)
          add_item(OP_RECEIVE, ($urandom_range(0, 4) != 0) ? 8'($urandom_range(8'h20, 8'h7E))
                                                           : 8'($urandom_range(1, 255)));
        add_item(OP_RECEIVE, ($urandom_range(0, 1) != 0) ? CH_CR : CH_LF);
        if ($urandom_range(0, 3) == 0) add_item(OP_RECEIVE, CH_LF);
      end else if (kind < 75) begin
        repeat ($urandom_range(1, 3)) add_item(OP_POP, 8'($urandom_range(0, 255)));
      end else if (kind < 82) begin
        add_item(OP_CLEAR, 8'($urandom_range(0, 255)));
      end else if (kind < 92) begin
        add_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end else begin
        add_item(OP_RECEIVE, 8'h00);
      end
    end
    // Let the directed part fully drain before random traffic starts.
    line_cmd_q[first_random].drain = 1'b1;

    // Hold reset low, then release it.
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    burst_left = 0;
    k = 0;
    while (k < line_cmd_q.size()) begin
      cmd = line_cmd_q[k];
      if (cmd.drain)
        while (pending_status_q.size() != 0) @(posedge clk_i);
      start_i      <= 1'b1;
      operation_i  <= cmd.op;
      rx_byte_i    <= cmd.rx;
      peek_index_i <= cmd.peek;
      // transfer happens at the first edge that sees busy low
      @(posedge clk_i);
      while (busy_o) @(posedge clk_i);
      st = next_line_status(cmd);
      pending_status_q.push_back(cmd.typed ? cmd.want : st);
      k++;
      if (burst_left > 0) burst_left--;
      // keep start high across back-to-back transfers inside a burst
      hold_high = (k < line_cmd_q.size()) && (burst_left > 0) && !line_cmd_q[k].drain;
      if (!hold_high) begin
        start_i <= 1'b0;
        if (burst_left == 0) begin
          repeat ($urandom_range(1, 12)) @(posedge clk_i);
          burst_left = $urandom_range(1, 40);
        end
      end
    end

    // Wait out the last results, then allow a full pop latency for stray strobes.
    while (pending_status_q.size() != 0) @(posedge clk_i);
    repeat (2 * DEPTH + 16) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### files.f
sv/slrb_pkg.sv
sv/slrb_ram.sv
sv/serial_line_receive_buffer.sv
tb/tb_top.sv
